### rtl/psplit_pkg.sv
// shared constants, types and helper functions of the particle splitter
`timescale 1ns / 1ps
`default_nettype none

package psplit_pkg;

    // largest refine factor the datapath is sized for
    localparam int MAX_REFINE = 8;

    // item field width, q16.16
    localparam int DATA_W   = 32;
    localparam int FIELDS   = 5;
    localparam int TDATA_W  = FIELDS * DATA_W;

    // configuration register widths and port sizing
    localparam int CFG_RF_W = 4;
    localparam int CFG_DX_W = 31;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    // derived widths of the split arithmetic
    localparam int R_W   = $clog2(MAX_REFINE + 1);
    localparam int D_W   = $clog2(MAX_REFINE * MAX_REFINE + 1);
    localparam int REM_W = (MAX_REFINE > 1) ? $clog2(MAX_REFINE * MAX_REFINE) : 1;
    localparam int OFS_W = (MAX_REFINE > 1) ? $clog2(MAX_REFINE) : 1;
    localparam int K_W   = (MAX_REFINE > 1) ? $clog2(2 * MAX_REFINE - 1) : 1;

    // weight divider: quotient bits resolved per cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = DATA_W / DIV_BITS;
    localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FP_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic REG_REFINE = 1'b0;
    localparam logic REG_STEP   = 1'b1;

    // one classified mother, ready for the back end
    typedef struct packed {
        logic [DATA_W-1:0] quo;        // weight / r^2
        logic [REM_W-1:0]  rem;        // weight mod r^2
        logic [D_W-1:0]    dsq;        // r^2
        logic [OFS_W-1:0]  peak;       // r-1, child index of the peak
        logic [K_W-1:0]    last;       // 2r-2, index of the last child
        logic [DATA_W-1:0] start_pos;  // position of child zero
        logic [DATA_W-1:0] vel_x;
        logic [DATA_W-1:0] vel_y;
        logic [DATA_W-1:0] vel_z;
    } psplit_entry_t;

    // refine factor clamped to 1 .. MAX_REFINE
    function automatic logic [R_W-1:0] eff_refine(input logic [CFG_RF_W-1:0] rf);
        logic [R_W-1:0] r;
        if (rf == '0)
            r = R_W'(1);
        else if (32'(rf) > MAX_REFINE)
            r = R_W'(MAX_REFINE);
        else
            r = R_W'(rf);
        return r;
    endfunction

    // r squared
    function automatic logic [D_W-1:0] refine_sq(input logic [R_W-1:0] r);
        logic [2*R_W-1:0] p;
        p = (2*R_W)'(r) * (2*R_W)'(r);
        return p[D_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/psplit_front.sv
// front end: takes a mother, divides its weight by r^2 and queues the result
`timescale 1ns / 1ps
`default_nettype none

module psplit_front
    import psplit_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [TDATA_W-1:0]  in_data,
    input  wire logic [CFG_RF_W-1:0] refine_factor,
    input  wire logic [CFG_DX_W-1:0] cell_step,
    input  wire logic                full,
    output logic                     push,
    output psplit_entry_t            push_entry
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    front_state_t        state_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [DATA_W-1:0]   div_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [D_W-1:0]      dsq_reg;
    logic [OFS_W-1:0]    peak_reg;
    logic [K_W-1:0]      last_reg;
    logic [DATA_W-1:0]   start_reg;
    logic [DATA_W-1:0]   vx_reg;
    logic [DATA_W-1:0]   vy_reg;
    logic [DATA_W-1:0]   vz_reg;

    logic [R_W-1:0]            r_eff;
    logic [R_W:0]              two_r;
    logic [OFS_W-1:0]          peak_in;
    logic [OFS_W+CFG_DX_W-1:0] ofs_prod;
    logic [DATA_W-1:0]         start_in;

    logic [REM_W:0]      div_trial;
    logic                div_ge;
    logic [REM_W-1:0]    rem_next;
    logic [DATA_W-1:0]   div_next;

    // classification of the incoming mother
    always_comb
    begin
        r_eff    = eff_refine(refine_factor);
        two_r    = {r_eff, 1'b0};
        peak_in  = OFS_W'(r_eff - R_W'(1));
        ofs_prod = (OFS_W+CFG_DX_W)'(peak_in) * (OFS_W+CFG_DX_W)'(cell_step);
        start_in = in_data[2*DATA_W-1:DATA_W] - ofs_prod[DATA_W-1:0];
    end

    // restoring division, several quotient bits per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        div_trial = '0;
        div_ge    = 1'b0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            div_trial = {rem_next, div_next[DATA_W-1]};
            div_ge    = (div_trial >= (REM_W+1)'(dsq_reg));
            if (div_ge)
                rem_next = REM_W'(div_trial - (REM_W+1)'(dsq_reg));
            else
                rem_next = div_trial[REM_W-1:0];
            div_next = {div_next[DATA_W-2:0], div_ge};
        end
    end

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !full;

    always_comb
    begin
        push_entry.quo       = div_reg;
        push_entry.rem       = rem_reg;
        push_entry.dsq       = dsq_reg;
        push_entry.peak      = peak_reg;
        push_entry.last      = last_reg;
        push_entry.start_pos = start_reg;
        push_entry.vel_x     = vx_reg;
        push_entry.vel_y     = vy_reg;
        push_entry.vel_z     = vz_reg;
    end

    // state machine and latched mother
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            div_reg   <= '0;
            rem_reg   <= '0;
            dsq_reg   <= D_W'(1);
            peak_reg  <= '0;
            last_reg  <= '0;
            start_reg <= '0;
            vx_reg    <= '0;
            vy_reg    <= '0;
            vz_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        div_reg   <= in_data[DATA_W-1:0];
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        dsq_reg   <= refine_sq(r_eff);
                        peak_reg  <= peak_in;
                        last_reg  <= K_W'(two_r - (R_W+1)'(2));
                        start_reg <= start_in;
                        vx_reg    <= in_data[3*DATA_W-1:2*DATA_W];
                        vy_reg    <= in_data[4*DATA_W-1:3*DATA_W];
                        vz_reg    <= in_data[5*DATA_W-1:4*DATA_W];
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    div_reg <= div_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + DCNT_W'(1);
                    if (cnt_reg == DCNT_W'(DIV_CYCLES - 1))
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/psplit_fifo.sv
// short queue of classified mothers between front and back
`timescale 1ns / 1ps
`default_nettype none

module psplit_fifo
    import psplit_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire psplit_entry_t  push_entry,
    input  wire logic           pop,
    output psplit_entry_t       pop_entry,
    output logic                full,
    output logic                empty
);

    psplit_entry_t     mem_reg [FIFO_DEPTH];
    logic [FP_W-1:0]   wr_ptr_reg;
    logic [FP_W-1:0]   rd_ptr_reg;
    logic [FC_W-1:0]   count_reg;

    assign full      = (count_reg == FC_W'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                if (wr_ptr_reg == FP_W'(FIFO_DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + FP_W'(1);
            end
            if (pop)
            begin
                if (rd_ptr_reg == FP_W'(FIFO_DEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + FP_W'(1);
            end
            if (push && !pop)
                count_reg <= count_reg + FC_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - FC_W'(1);
        end
    end

endmodule

`default_nettype wire

### rtl/psplit_back.sv
// back end: walks the children of one mother, one child per cycle while the output takes them
`timescale 1ns / 1ps
`default_nettype none

module psplit_back
    import psplit_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [CFG_DX_W-1:0] cell_step,
    input  wire logic                empty,
    input  wire psplit_entry_t       entry,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [TDATA_W-1:0]       out_data,
    output logic                     out_last
);

    logic                active_reg;
    psplit_entry_t       cur_reg;
    logic [K_W-1:0]      k_reg;
    logic [DATA_W-1:0]   wq_reg;
    logic [REM_W-1:0]    wf_reg;
    logic [DATA_W-1:0]   pos_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_weight_reg;
    logic [DATA_W-1:0]   out_pos_reg;
    logic [DATA_W-1:0]   out_vx_reg;
    logic [DATA_W-1:0]   out_vy_reg;
    logic [DATA_W-1:0]   out_vz_reg;
    logic                out_last_reg;

    logic                emit;
    logic                at_last;
    logic                rising;
    logic                load;
    logic [D_W:0]        sum_v;
    logic [DATA_W-1:0]   wq_next;
    logic [REM_W-1:0]    wf_next;

    assign emit    = active_reg && (!out_valid_reg || out_ready);
    assign at_last = (k_reg == cur_reg.last);
    assign rising  = (k_reg < K_W'(cur_reg.peak));
    assign load    = !empty && (!active_reg || (emit && at_last));
    assign pop     = load;

    // weight of the next child: quotient and remainder of w*c / r^2 moved by one c
    always_comb
    begin
        sum_v   = (D_W+1)'(wf_reg) + (D_W+1)'(cur_reg.rem);
        wq_next = wq_reg;
        wf_next = wf_reg;
        if (rising)
        begin
            if (sum_v >= (D_W+1)'(cur_reg.dsq))
            begin
                wf_next = REM_W'(sum_v - (D_W+1)'(cur_reg.dsq));
                wq_next = wq_reg + cur_reg.quo + DATA_W'(1);
            end
            else
            begin
                wf_next = REM_W'(sum_v);
                wq_next = wq_reg + cur_reg.quo;
            end
        end
        else
        begin
            if (wf_reg >= cur_reg.rem)
            begin
                wf_next = wf_reg - cur_reg.rem;
                wq_next = wq_reg - cur_reg.quo;
            end
            else
            begin
                wf_next = REM_W'((D_W+1)'(wf_reg) + (D_W+1)'(cur_reg.dsq)
                                 - (D_W+1)'(cur_reg.rem));
                wq_next = wq_reg - cur_reg.quo - DATA_W'(1);
            end
        end
    end

    // child walk and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_reg        <= '0;
            k_reg          <= '0;
            wq_reg         <= '0;
            wf_reg         <= '0;
            pos_reg        <= '0;
            out_weight_reg <= '0;
            out_pos_reg    <= '0;
            out_vx_reg     <= '0;
            out_vy_reg     <= '0;
            out_vz_reg     <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg  <= 1'b1;
                out_weight_reg <= wq_reg;
                out_pos_reg    <= pos_reg;
                out_vx_reg     <= cur_reg.vel_x;
                out_vy_reg     <= cur_reg.vel_y;
                out_vz_reg     <= cur_reg.vel_z;
                out_last_reg   <= at_last;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (load)
            begin
                active_reg <= 1'b1;
                cur_reg    <= entry;
                k_reg      <= '0;
                wq_reg     <= entry.quo;
                wf_reg     <= entry.rem;
                pos_reg    <= entry.start_pos;
            end
            else if (emit)
            begin
                if (at_last)
                    active_reg <= 1'b0;
                k_reg   <= k_reg + K_W'(1);
                wq_reg  <= wq_next;
                wf_reg  <= wf_next;
                pos_reg <= pos_reg + DATA_W'(cell_step);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {out_vz_reg, out_vy_reg, out_vx_reg, out_pos_reg, out_weight_reg};

endmodule

`default_nettype wire

### rtl/particle_split_triangular_1d.sv
// top level of the 1d triangular particle splitter
//
//  channel   role                  fields
//  s_axis    mother particle in    tdata: weight, pos, vel x, vel y, vel z
//  m_axis    child particle out    tdata: weight, pos, vel x, vel y, vel z; tlast
//  apb       configuration         0x0 refine_factor, 0x4 cell_step
//
// the front takes a mother, runs the divider for weight / r^2 (8 quotient
// bits a cycle) and queues it once the queue has room, and only then takes
// the next mother; the back emits 2r-1 children, one per cycle while the
// output takes them; a mother goes through the divider, the queue, the child
// walk registers and the output register before its first child is presented
// a two-entry queue lets front and back stall on their own; the child walk
// halts while the output register holds a child that is not taken
// after reset the block is ready at once: no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module particle_split_triangular_1d
    import psplit_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // mother item in
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [31:0] mother_weight, [63:32] mother_pos, [95:64] vel_x_in,
    // [127:96] vel_y_in, [159:128] vel_z_in
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    // child item out
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [31:0] child_weight, [63:32] child_pos, [95:64] vel_x_out,
    // [127:96] vel_y_out, [159:128] vel_z_out
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic                    m_axis_tlast,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [CFG_AW-1:0]  paddr,
    input  wire logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]       prdata,
    output logic                    pready
);

    logic [CFG_RF_W-1:0] refine_factor_reg;
    logic [CFG_DX_W-1:0] cell_step_reg;
    logic                cfg_write;
    logic                reg_idx;

    logic                fifo_push;
    logic                fifo_pop;
    logic                fifo_full;
    logic                fifo_empty;
    psplit_entry_t       push_entry;
    psplit_entry_t       pop_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[CFG_AW-1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refine_factor_reg <= CFG_RF_W'(2);
            cell_step_reg     <= CFG_DX_W'(65536);
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_REFINE: refine_factor_reg <= pwdata[CFG_RF_W-1:0];
                REG_STEP:   cell_step_reg     <= pwdata[CFG_DX_W-1:0];
                default:    ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            REG_REFINE: prdata = CFG_DW'(refine_factor_reg);
            REG_STEP:   prdata = CFG_DW'(cell_step_reg);
            default:    prdata = '0;
        endcase
    end

    psplit_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_data       (s_axis_tdata),
        .refine_factor (refine_factor_reg),
        .cell_step     (cell_step_reg),
        .full          (fifo_full),
        .push          (fifo_push),
        .push_entry    (push_entry)
    );

    psplit_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fifo_push),
        .push_entry (push_entry),
        .pop        (fifo_pop),
        .pop_entry  (pop_entry),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    psplit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_step (cell_step_reg),
        .empty     (fifo_empty),
        .entry     (pop_entry),
        .pop       (fifo_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // queue is never written when full
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full)
        else $error("queue written while full");

    // queue is never read when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("queue read while empty");

    // a push with no pop leaves the queue non-empty next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_push && !fifo_pop) |=> !fifo_empty)
        else $error("queued mother lost");

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench of the 1d triangular particle splitter
`timescale 1ns / 1ps

module testbench;
    import psplit_pkg::*;

    // one particle as it travels in tdata, weight in the lowest bits
    typedef struct packed {
        logic [DATA_W-1:0] vel_z;
        logic [DATA_W-1:0] vel_y;
        logic [DATA_W-1:0] vel_x;
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] weight;
    } particle_t;

    // one awaited child and its last flag
    typedef struct packed {
        particle_t child;
        logic      last;
    } child_exp_t;

    // rows of the directed part
    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic                    reg_idx;
        logic [CFG_DW-1:0]       value;
        particle_t               mother;
        logic                    typed;
        logic [2:0][DATA_W-1:0]  typed_w;
        logic [2:0][DATA_W-1:0]  typed_p;
    } split_row_t;

    localparam int RANDOM_ITEMS = 200;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_CYCLES = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // [31:0] mother_weight, [63:32] mother_pos, [95:64] vel_x_in,
    // [127:96] vel_y_in, [159:128] vel_z_in
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [31:0] child_weight, [63:32] child_pos, [95:64] vel_x_out,
    // [127:96] vel_y_out, [159:128] vel_z_out
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [CFG_AW-1:0]  paddr = '0;
    logic [CFG_DW-1:0]  pwdata = '0;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    // shadow of the configuration registers
    logic [CFG_RF_W-1:0] shadow_refine = CFG_RF_W'(2);
    logic [CFG_DX_W-1:0] shadow_step = CFG_DX_W'(32'h0001_0000);

    child_exp_t  expected_children [$];
    split_row_t  split_rows [$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_kicks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    particle_split_triangular_1d i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // refine factor as the splitter uses it
    function automatic int unsigned split_ratio(input logic [CFG_RF_W-1:0] rf);
        if (rf == '0)
            return 1;
        if (int'(rf) > MAX_REFINE)
            return MAX_REFINE;
        return int'(rf);
    endfunction

    // queue the children of one mother: triangular weights, spaced positions
    function automatic void predict_children(input particle_t mother);
        int unsigned r;
        int unsigned n;
        logic [63:0] dsq;
        logic [63:0] coef;
        logic [63:0] offset;
        logic [63:0] prod;
        child_exp_t  e;
        r = split_ratio(shadow_refine);
        n = 2 * r - 1;
        dsq = 64'(r * r);
        coef = 64'd1;
        for (int unsigned k = 0; k < n; k++)
        begin
            e.child = mother;
            prod = (64'(mother.weight) * coef) / dsq;
            e.child.weight = prod[DATA_W-1:0];
            if (k < r - 1)
            begin
                offset = 64'((r - 1) - k) * 64'(shadow_step);
                e.child.pos = mother.pos - offset[DATA_W-1:0];
                coef = coef + 64'd1;
            end
            else
            begin
                offset = 64'(k - (r - 1)) * 64'(shadow_step);
                e.child.pos = mother.pos + offset[DATA_W-1:0];
                coef = coef - 64'd1;
            end
            e.last = (k == n - 1);
            expected_children.insert(expected_children.size(), e);
        end
    endfunction

    // children typed in the directed rows, for r of one or two
    function automatic void queue_typed(input split_row_t row);
        int unsigned n;
        child_exp_t  e;
        n = 2 * split_ratio(shadow_refine) - 1;
        for (int unsigned k = 0; k < n; k++)
        begin
            e.child = row.mother;
            e.child.weight = row.typed_w[k];
            e.child.pos = row.typed_p[k];
            e.last = (k == n - 1);
            expected_children.insert(expected_children.size(), e);
        end
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // directed row builders
    function automatic void add_cfg(input logic idx, input logic [CFG_DW-1:0] value);
        split_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.value = value;
        split_rows.insert(split_rows.size(), row);
    endfunction

    function automatic void add_item(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] p,
                                     input logic [DATA_W-1:0] vx, input logic [DATA_W-1:0] vy,
                                     input logic [DATA_W-1:0] vz);
        split_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.mother = '{vel_z: vz, vel_y: vy, vel_x: vx, pos: p, weight: w};
        split_rows.insert(split_rows.size(), row);
    endfunction

    function automatic void add_typed(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] p,
                                      input logic [DATA_W-1:0] vx,
                                      input logic [DATA_W-1:0] vy,
                                      input logic [DATA_W-1:0] vz,
                                      input logic [2:0][DATA_W-1:0] tw,
                                      input logic [2:0][DATA_W-1:0] tp);
        split_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.mother = '{vel_z: vz, vel_y: vy, vel_x: vx, pos: p, weight: w};
        row.typed = 1'b1;
        row.typed_w = tw;
        row.typed_p = tp;
        split_rows.insert(split_rows.size(), row);
    endfunction

    // random mother with a bias towards the field extremes
    function automatic particle_t random_mother();
        particle_t m;
        case ($urandom_range(5))
            0: m.weight = '0;
            1: m.weight = '1;
            2: m.weight = DATA_W'($urandom_range(255));
            default: m.weight = $urandom;
        endcase
        case ($urandom_range(5))
            0: m.pos = 32'h7FFF_FFFF;
            1: m.pos = 32'h8000_0000;
            default: m.pos = $urandom;
        endcase
        m.vel_x = $urandom;
        m.vel_y = $urandom;
        m.vel_z = $urandom;
        return m;
    endfunction

    // offer one mother, with random gaps, and wait for its acceptance
    task automatic send_mother(input particle_t mother);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= mother;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
        logic [CFG_DW-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_REFINE)
        begin
            shadow_refine = value[CFG_RF_W-1:0];
            want = CFG_DW'(shadow_refine);
        end
        else
        begin
            shadow_step = value[CFG_DX_W-1:0];
            want = CFG_DW'(shadow_step);
        end
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $display("%0t mismatch register %0d expected %h actual %h", $time, idx, want,
                     prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every child has come, then let the block drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_children.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_config();
        logic [CFG_DW-1:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[CFG_RF_W-1:0] = '0;
            1: v[CFG_RF_W-1:0] = CFG_RF_W'($urandom_range(15, 9));
            2: v[CFG_RF_W-1:0] = CFG_RF_W'(MAX_REFINE);
            default: v[CFG_RF_W-1:0] = CFG_RF_W'($urandom_range(4, 1));
        endcase
        write_reg(REG_REFINE, v);
        v = $urandom;
        case ($urandom_range(7))
            0: v[CFG_DX_W-1:0] = '0;
            1: v[CFG_DX_W-1:0] = '1;
            2: v = $urandom;
            default: v[CFG_DX_W-1:0] = CFG_DX_W'($urandom_range(32'h0004_0000, 1));
        endcase
        write_reg(REG_STEP, v);
    endtask

    // child checker and receiver back-pressure
    always @(posedge clk)
    begin : child_monitor
        child_exp_t want;
        particle_t  got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_children.size() == 0)
            begin
                $display("%0t mismatch unexpected child expected none actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_children.pop_front();
                check_field("child_weight", want.child.weight, got.weight);
                check_field("child_pos", want.child.pos, got.pos);
                check_field("vel_x_out", want.child.vel_x, got.vel_x);
                check_field("vel_y_out", want.child.vel_y, got.vel_y);
                check_field("vel_z_out", want.child.vel_z, got.vel_z);
                check_field("last_child", DATA_W'(want.last), DATA_W'(m_axis_tlast));
            end
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_kicks != hold_seen)
        begin
            hold_seen = hold_kicks;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // stimulus
    initial
    begin : stimulus
        int sent;
        int batch;
        int count;
        // reset values: r = 2, dx = 1.0
        add_typed(32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                  {32'h0, 32'h0, 32'h0},
                  {32'h0001_0000, 32'h0, 32'hFFFF_0000});
        add_typed(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  {32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h3FFF_FFFF},
                  {32'h8000_FFFF, 32'h7FFF_FFFF, 32'h7FFE_FFFF});
        add_typed(32'h0004_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                  {32'h0001_0000, 32'h0002_0000, 32'h0001_0000},
                  {32'h8001_0000, 32'h8000_0000, 32'h7FFF_0000});
        // truncation of the weight
        add_typed(32'h3, 32'h5, 32'h1234_5678, 32'hFEDC_BA98, 32'h5555_AAAA,
                  {32'h0, 32'h1, 32'h0},
                  {32'h0001_0005, 32'h5, 32'hFFFF_0005});
        // refine factor zero acts as one
        add_cfg(REG_REFINE, 32'h0);
        add_typed(32'h1234_5678, 32'hDEAD_BEEF, 32'hAAAA_5555, 32'h0F0F_F0F0, 32'h8000_0001,
                  {32'h0, 32'h0, 32'h1234_5678}, {32'h0, 32'h0, 32'hDEAD_BEEF});
        add_typed(32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  {32'h0, 32'h0, 32'hFFFF_FFFF}, {32'h0, 32'h0, 32'h8000_0000});
        add_cfg(REG_REFINE, 32'h1);
        add_item(32'h0001_8000, 32'hFFFF_0000, 32'h1, 32'h2, 32'h3);
        // above the maximum saturates, widest step wraps the position
        add_cfg(REG_REFINE, 32'hF);
        add_cfg(REG_STEP, 32'hFFFF_FFFF);
        add_item(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        add_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        add_item(32'h0040_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_cfg(REG_REFINE, 32'h9);
        add_cfg(REG_STEP, 32'h0);
        add_item(32'hCAFE_F00D, 32'h8000_0000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
        add_cfg(REG_REFINE, 32'h8);
        add_cfg(REG_STEP, 32'h1);
        add_item(32'h0000_0040, 32'h8000_0003, 32'h7FFF_FFFF, 32'h0, 32'h1);
        add_item(32'hFFFF_FFFF, 32'h7FFF_FFFC, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666);
        // upper bits of the write data are dropped
        add_cfg(REG_REFINE, 32'hFFFF_FFF3);
        add_cfg(REG_STEP, 32'h8001_8000);
        add_item(32'h0009_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        add_item(32'h0000_0008, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(32'hFFFF_FFFF, 32'h7FFF_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_FF00);
        add_cfg(REG_REFINE, 32'h4);
        add_cfg(REG_STEP, 32'h4000_0000);
        add_item(32'h1000_0000, 32'h4000_0000, 32'h9, 32'h8, 32'h7);
        add_item(32'h7FFF_FFFF, 32'hC000_0000, 32'h6, 32'h5, 32'h4);
        add_cfg(REG_REFINE, 32'h2);
        add_cfg(REG_STEP, 32'h0001_0000);
        add_typed(32'h8, 32'h0, 32'h0, 32'h0, 32'h0,
                  {32'h2, 32'h4, 32'h2}, {32'h0001_0000, 32'h0, 32'hFFFF_0000});

        // reset
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        send_idle_pct = 33;
        recv_idle_pct = 49;
        foreach (split_rows[i])
        begin
            if (split_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(split_rows[i].reg_idx, split_rows[i].value);
            end
            else
            begin
                send_mother(split_rows[i].mother);
                if (split_rows[i].typed)
                    queue_typed(split_rows[i]);
                else
                    predict_children(split_rows[i].mother);
            end
        end

        // random batches, each under a fresh setting
        sent = 0;
        batch = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ((sent * 3) / RANDOM_ITEMS)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            settle();
            random_config();
            // long receiver hold-off while mothers keep coming
            if (batch == 2 || batch == 9)
                hold_kicks = hold_kicks + 1;
            count = $urandom_range(20, 6);
            for (int j = 0; j < count && sent < RANDOM_ITEMS; j++)
            begin
                begin : one_mother
                    particle_t m;
                    m = random_mother();
                    send_mother(m);
                    predict_children(m);
                end
                sent++;
            end
            batch++;
        end

        // drain and report
        settle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
